/* design/jeig_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package jeig_pkg;

	// shared multiplier operand and product widths
	localparam int MUL_W  = 35;
	localparam int PROD_W = 70;

	// configuration register indexes
	localparam logic REG_ITER_LIMIT = 1'b0;
	localparam logic REG_TOLERANCE  = 1'b1;

	localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_PIVOT,
		ST_HH,
		ST_VV,
		ST_SQ1,
		ST_SQ1W,
		ST_DV1,
		ST_DV1W,
		ST_TT,
		ST_DV2,
		ST_DV2W,
		ST_SQ2,
		ST_SQ2W,
		ST_CC,
		ST_SQ3,
		ST_SQ3W,
		ST_MAC_MUL,
		ST_MAC_ACC,
		ST_COPY,
		ST_OFF_MUL,
		ST_OFF_ACC,
		ST_OFF_CHK,
		ST_EMIT
	} state_t;

	typedef enum logic {
		DS_DIV,
		DS_SQRT
	} ds_mode_t;

	typedef struct packed {
		logic        start;
		ds_mode_t    mode;
		logic [63:0] x;
		logic [63:0] d;
	} ds_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] res;
	} ds_rsp_t;

	// entry (row, col) of the rotation matrix for pivot (p, q)
	function automatic logic signed [31:0] rot_entry(
		input logic [1:0] row,
		input logic [1:0] col,
		input logic [1:0] p,
		input logic [1:0] q,
		input logic signed [31:0] c,
		input logic signed [31:0] s
	);
		logic signed [31:0] r;
		begin
			if (row == col) begin
				r = (row == p || row == q) ? c : ONE_Q30;
			end else if (row == p && col == q) begin
				r = s;
			end else if (row == q && col == p) begin
				r = -s;
			end else begin
				r = '0;
			end
			return r;
		end
	endfunction

endpackage

`default_nettype wire

/* design/jeig_mul.sv */
`timescale 1ns / 1ps
`default_nettype none

// registered signed multiplier shared by the whole sequencer
module jeig_mul (
	input  wire logic                                  clk,
	input  wire logic signed [jeig_pkg::MUL_W-1:0]     x,
	input  wire logic signed [jeig_pkg::MUL_W-1:0]     y,
	output logic signed [jeig_pkg::PROD_W-1:0]         p
);

	always_ff @(posedge clk) begin
		p <= x * y;
	end

endmodule

`default_nettype wire

/* design/jeig_divsqrt.sv */
`timescale 1ns / 1ps
`default_nettype none

// bit-serial unsigned 64-bit divider and floor square root
module jeig_divsqrt (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire jeig_pkg::ds_req_t req,
	output jeig_pkg::ds_rsp_t      rsp
);

	logic               busy_q;
	logic               done_q;
	logic [5:0]         cnt_q;
	jeig_pkg::ds_mode_t mode_q;
	logic [64:0]        rem_q;
	logic [63:0]        quo_q;
	logic [63:0]        den_q;

	logic [64:0] shifted;
	logic [63:0] trial;
	logic        last;

	assign shifted = {rem_q[63:0], quo_q[63]};
	assign trial   = quo_q + den_q;
	assign last    = (mode_q == jeig_pkg::DS_DIV) ? (cnt_q == 6'd63) : (cnt_q == 6'd31);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			mode_q <= req.mode;
			if (req.mode == jeig_pkg::DS_DIV) begin
				rem_q <= '0;
				quo_q <= req.x;
				den_q <= req.d;
			end else begin
				rem_q <= {1'b0, req.x};
				quo_q <= '0;
				den_q <= 64'h4000_0000_0000_0000;
			end
		end else if (busy_q) begin
			if (mode_q == jeig_pkg::DS_DIV) begin
				// restoring step, one quotient bit
				if (shifted >= {1'b0, den_q}) begin
					rem_q <= shifted - {1'b0, den_q};
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= shifted;
					quo_q <= {quo_q[62:0], 1'b0};
				end
			end else begin
				// digit-by-digit root, one result bit
				if (rem_q[63:0] >= trial) begin
					rem_q <= {1'b0, rem_q[63:0] - trial};
					quo_q <= (quo_q >> 1) + den_q;
				end else begin
					quo_q <= quo_q >> 1;
				end
				den_q <= den_q >> 2;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = quo_q;

endmodule

`default_nettype wire

/* design/jacobi_eigen_3x3_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Jacobi eigen-decomposition of one symmetric 3x3 matrix (Q16.16 in, Q16.16
// eigenvalues and Q2.30 eigenvectors out). A transaction is accepted when start
// is high and busy is low; busy then stays high until the cycle that shows the
// third result. Results come as three one-cycle done strobes on consecutive
// cycles, axis 0, 1, 2, with final_axis on the last; the receiver cannot stall
// them, so it must take each result in the cycle it is shown. Each rotation
// runs two divisions and three roots on the bit-serial divider/root unit and
// 81 multiply-accumulates plus 10 squares on one shared multiplier. At most
// iteration_limit rotations are applied, fewer when the tolerance ends the
// rotations. The user must write configuration through cfg_we/cfg_index/
// cfg_data only while idle; the block itself does not enforce it.
module jacobi_eigen_3x3_top #(
	parameter int WORD_WIDTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration write port
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [30:0]        cfg_data,
	// command side
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [31:0] entry_00,
	input  wire logic signed [31:0] entry_01,
	input  wire logic signed [31:0] entry_02,
	input  wire logic signed [31:0] entry_11,
	input  wire logic signed [31:0] entry_12,
	input  wire logic signed [31:0] entry_22,
	// result side
	output logic                    done,
	output logic [1:0]              axis_index,
	output logic signed [31:0]      eigenvalue,
	output logic signed [31:0]      vector_x,
	output logic signed [31:0]      vector_y,
	output logic signed [31:0]      vector_z,
	output logic                    final_axis
);

	// stored word width, held to what the 32-bit fields can carry
	localparam int SB = (WORD_WIDTH < 24) ? 24 : ((WORD_WIDTH > 32) ? 32 : WORD_WIDTH);
	localparam logic signed [39:0] SMAX = (40'sd1 <<< (SB - 1)) - 40'sd1;
	localparam logic signed [39:0] SMIN = -SMAX - 40'sd1;
	localparam logic signed [39:0] MMAX = (40'sd1 <<< 32) - 40'sd1;
	localparam logic signed [39:0] MMIN = -MMAX - 40'sd1;
	localparam logic signed [39:0] ONE_FULL = 40'sd1 <<< 30;
	// identity value of the vector store after saturation
	localparam logic signed [SB-1:0] V_ONE = SB'((ONE_FULL > SMAX) ? SMAX : ONE_FULL);
	localparam int MW = jeig_pkg::MUL_W;
	localparam int PW = jeig_pkg::PROD_W;

	function automatic logic signed [SB-1:0] sat_store(input logic signed [39:0] x);
		if (x > SMAX) begin
			return SB'(SMAX);
		end else if (x < SMIN) begin
			return SB'(SMIN);
		end
		return x[SB-1:0];
	endfunction

	function automatic logic signed [33:0] sat_mid(input logic signed [39:0] x);
		if (x > MMAX) begin
			return 34'(MMAX);
		end else if (x < MMIN) begin
			return 34'(MMIN);
		end
		return x[33:0];
	endfunction

	function automatic logic signed [SB-1:0] sat_in(input logic signed [31:0] x);
		return sat_store(40'(x));
	endfunction

	// magnitude; the most negative word maps to its unsigned value
	function automatic logic [SB-1:0] mag(input logic signed [SB-1:0] x);
		return x[SB-1] ? SB'(-x) : SB'(x);
	endfunction

	// control state
	jeig_pkg::state_t state_q, state_d;
	logic [7:0]  iter_limit_q;
	logic [30:0] tolerance_q;
	logic [7:0]  it_q;
	logic        done_q;

	// matrix store, intermediate product and eigenvector store
	logic signed [SB-1:0] a_q [0:2][0:2];
	logic signed [SB-1:0] v_q [0:2][0:2];
	logic signed [33:0]   b_q [0:2][0:2];

	// rotation setup
	logic [1:0]         p_q, q_q;
	logic [SB-1:0]      h_q, vmag_q;
	logic               neg_q;
	logic [63:0]        w_q, x_q;
	logic signed [31:0] c_q, s_q;

	// product sequencing
	logic [1:0]         phase_q, i_q, j_q, k_q;
	logic signed [PW-1:0] acc_q;
	logic [2:0]         off_idx_q;
	logic [49:0]        off_q;
	logic [1:0]         emit_idx_q;

	// output registers
	logic [1:0]         axis_q;
	logic signed [31:0] eig_q, vx_q, vy_q, vz_q;
	logic               final_q;

	// shared units
	logic signed [MW-1:0] mul_x, mul_y;
	logic signed [PW-1:0] mul_p;
	jeig_pkg::ds_req_t    ds_req;
	jeig_pkg::ds_rsp_t    ds_rsp;

	jeig_mul u_mul (
		.clk (clk),
		.x   (mul_x),
		.y   (mul_y),
		.p   (mul_p)
	);

	jeig_divsqrt u_ds (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ds_req),
		.rsp    (ds_rsp)
	);

	// pivot choice: largest upper off-diagonal, later pair wins ties
	logic [SB-1:0]      m01, m02, m12, best;
	logic [1:0]         piv_p, piv_q;
	logic signed [SB:0] dd;
	logic [SB:0]        dd_mag;
	logic signed [SB-1:0] app, aqq, apq;

	always_comb begin
		m01   = mag(a_q[0][1]);
		m02   = mag(a_q[0][2]);
		m12   = mag(a_q[1][2]);
		best  = m01;
		piv_p = 2'd0;
		piv_q = 2'd1;
		if (m02 >= best) begin
			best  = m02;
			piv_q = 2'd2;
		end
		if (m12 >= best) begin
			best  = m12;
			piv_p = 2'd1;
			piv_q = 2'd2;
		end
		app    = a_q[piv_p][piv_p];
		aqq    = a_q[piv_q][piv_q];
		apq    = a_q[piv_p][piv_q];
		dd     = (SB+1)'(aqq) - (SB+1)'(app);
		dd_mag = dd[SB] ? (SB+1)'(-dd) : (SB+1)'(dd);
	end

	// multiply-accumulate operands and rounding
	logic signed [31:0]   rot_a, rot_b;
	logic signed [PW-1:0] mac_sum, rnd_full;
	logic signed [39:0]   rnd;
	logic                 mac_last;
	logic signed [SB-1:0] off_val;

	always_comb begin
		rot_a    = jeig_pkg::rot_entry(k_q, j_q, p_q, q_q, c_q, s_q);
		rot_b    = jeig_pkg::rot_entry(k_q, i_q, p_q, q_q, c_q, s_q);
		mac_sum  = (k_q == 2'd0) ? mul_p : acc_q + mul_p;
		rnd_full = mac_sum + (PW'(1) <<< 29);
		rnd      = rnd_full[69:30];
		mac_last = (i_q == 2'd2) && (j_q == 2'd2) && (k_q == 2'd2);
		case (off_idx_q)
			3'd0:    off_val = a_q[0][1];
			3'd1:    off_val = a_q[0][2];
			3'd2:    off_val = a_q[1][0];
			3'd3:    off_val = a_q[1][2];
			3'd4:    off_val = a_q[2][0];
			default: off_val = a_q[2][1];
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			jeig_pkg::ST_IDLE:    if (start) state_d = jeig_pkg::ST_PIVOT;
			jeig_pkg::ST_PIVOT: begin
				if (it_q >= iter_limit_q || best == '0) begin
					state_d = jeig_pkg::ST_EMIT;
				end else begin
					state_d = jeig_pkg::ST_HH;
				end
			end
			jeig_pkg::ST_HH:      state_d = jeig_pkg::ST_VV;
			jeig_pkg::ST_VV:      state_d = jeig_pkg::ST_SQ1;
			jeig_pkg::ST_SQ1:     state_d = jeig_pkg::ST_SQ1W;
			jeig_pkg::ST_SQ1W:    if (ds_rsp.done) state_d = jeig_pkg::ST_DV1;
			jeig_pkg::ST_DV1:     state_d = jeig_pkg::ST_DV1W;
			jeig_pkg::ST_DV1W:    if (ds_rsp.done) state_d = jeig_pkg::ST_TT;
			jeig_pkg::ST_TT:      state_d = jeig_pkg::ST_DV2;
			jeig_pkg::ST_DV2:     state_d = jeig_pkg::ST_DV2W;
			jeig_pkg::ST_DV2W:    if (ds_rsp.done) state_d = jeig_pkg::ST_SQ2;
			jeig_pkg::ST_SQ2:     state_d = jeig_pkg::ST_SQ2W;
			jeig_pkg::ST_SQ2W:    if (ds_rsp.done) state_d = jeig_pkg::ST_CC;
			jeig_pkg::ST_CC:      state_d = jeig_pkg::ST_SQ3;
			jeig_pkg::ST_SQ3:     state_d = jeig_pkg::ST_SQ3W;
			jeig_pkg::ST_SQ3W:    if (ds_rsp.done) state_d = jeig_pkg::ST_MAC_MUL;
			jeig_pkg::ST_MAC_MUL: state_d = jeig_pkg::ST_MAC_ACC;
			jeig_pkg::ST_MAC_ACC: begin
				if (mac_last && phase_q == 2'd2) begin
					state_d = jeig_pkg::ST_COPY;
				end else begin
					state_d = jeig_pkg::ST_MAC_MUL;
				end
			end
			jeig_pkg::ST_COPY:    state_d = jeig_pkg::ST_OFF_MUL;
			jeig_pkg::ST_OFF_MUL: state_d = jeig_pkg::ST_OFF_ACC;
			jeig_pkg::ST_OFF_ACC: begin
				if (off_idx_q == 3'd5) begin
					state_d = jeig_pkg::ST_OFF_CHK;
				end else begin
					state_d = jeig_pkg::ST_OFF_MUL;
				end
			end
			jeig_pkg::ST_OFF_CHK: begin
				if (off_q < 50'(tolerance_q)) begin
					state_d = jeig_pkg::ST_EMIT;
				end else begin
					state_d = jeig_pkg::ST_PIVOT;
				end
			end
			jeig_pkg::ST_EMIT:    if (emit_idx_q == 2'd2) state_d = jeig_pkg::ST_IDLE;
			default:              state_d = jeig_pkg::ST_IDLE;
		endcase
	end

	// unit operands per state
	always_comb begin
		mul_x        = '0;
		mul_y        = '0;
		ds_req.start = 1'b0;
		ds_req.mode  = jeig_pkg::DS_SQRT;
		ds_req.x     = '0;
		ds_req.d     = '0;
		case (state_q)
			jeig_pkg::ST_HH: begin
				mul_x = MW'(h_q);
				mul_y = MW'(h_q);
			end
			jeig_pkg::ST_VV: begin
				mul_x = MW'(vmag_q);
				mul_y = MW'(vmag_q);
			end
			jeig_pkg::ST_TT: begin
				mul_x = MW'(x_q[31:0]);
				mul_y = MW'(x_q[31:0]);
			end
			jeig_pkg::ST_CC: begin
				mul_x = MW'(c_q);
				mul_y = MW'(c_q);
			end
			jeig_pkg::ST_MAC_MUL: begin
				case (phase_q)
					2'd0: begin
						mul_x = MW'(a_q[i_q][k_q]);
						mul_y = MW'(rot_a);
					end
					2'd1: begin
						mul_x = MW'(rot_b);
						mul_y = MW'(b_q[k_q][j_q]);
					end
					default: begin
						mul_x = MW'(v_q[i_q][k_q]);
						mul_y = MW'(rot_a);
					end
				endcase
			end
			jeig_pkg::ST_OFF_MUL: begin
				mul_x = MW'(mag(off_val));
				mul_y = MW'(mag(off_val));
			end
			jeig_pkg::ST_SQ1: begin
				// r = isqrt(h*h + v*v)
				ds_req.start = 1'b1;
				ds_req.x     = w_q + mul_p[63:0];
			end
			jeig_pkg::ST_DV1: begin
				// |t| = v * 2^30 / (h + r)
				ds_req.start = 1'b1;
				ds_req.mode  = jeig_pkg::DS_DIV;
				ds_req.x     = 64'(vmag_q) << 30;
				ds_req.d     = 64'(h_q) + x_q;
			end
			jeig_pkg::ST_DV2: begin
				// c^2 = 2^60 / (t*t + 1)
				ds_req.start = 1'b1;
				ds_req.mode  = jeig_pkg::DS_DIV;
				ds_req.x     = 64'h1000_0000_0000_0000;
				ds_req.d     = 64'(mul_p[63:30]) + 64'h4000_0000;
			end
			jeig_pkg::ST_SQ2: begin
				ds_req.start = 1'b1;
				ds_req.x     = x_q << 30;
			end
			jeig_pkg::ST_SQ3: begin
				// s = sqrt(1 - c*c)
				ds_req.start = 1'b1;
				ds_req.x     = 64'h1000_0000_0000_0000 - mul_p[63:0];
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= jeig_pkg::ST_IDLE;
			iter_limit_q <= 8'd32;
			tolerance_q  <= 31'd1;
			it_q         <= '0;
			done_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == jeig_pkg::ST_EMIT);
			if (cfg_we) begin
				case (cfg_index)
					jeig_pkg::REG_ITER_LIMIT: iter_limit_q <= cfg_data[7:0];
					jeig_pkg::REG_TOLERANCE:  tolerance_q  <= cfg_data;
					default: begin
					end
				endcase
			end
			if (state_q == jeig_pkg::ST_IDLE) begin
				it_q <= '0;
			end else if (state_q == jeig_pkg::ST_OFF_CHK) begin
				it_q <= it_q + 8'd1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			jeig_pkg::ST_IDLE: begin
				if (start) begin
					a_q[0][0] <= sat_in(entry_00);
					a_q[0][1] <= sat_in(entry_01);
					a_q[1][0] <= sat_in(entry_01);
					a_q[0][2] <= sat_in(entry_02);
					a_q[2][0] <= sat_in(entry_02);
					a_q[1][1] <= sat_in(entry_11);
					a_q[1][2] <= sat_in(entry_12);
					a_q[2][1] <= sat_in(entry_12);
					a_q[2][2] <= sat_in(entry_22);
					for (int r = 0; r < 3; r++) begin
						for (int c = 0; c < 3; c++) begin
							v_q[r][c] <= (r == c) ? V_ONE : '0;
						end
					end
					emit_idx_q <= '0;
				end
			end
			jeig_pkg::ST_PIVOT: begin
				p_q    <= piv_p;
				q_q    <= piv_q;
				h_q    <= dd_mag[SB:1];
				vmag_q <= mag(apq);
				neg_q  <= (dd != '0) && (dd[SB] != apq[SB-1]);
			end
			jeig_pkg::ST_VV:   w_q <= mul_p[63:0];
			jeig_pkg::ST_SQ1W: if (ds_rsp.done) x_q <= ds_rsp.res;
			jeig_pkg::ST_DV1W: if (ds_rsp.done) x_q <= ds_rsp.res;
			jeig_pkg::ST_DV2W: if (ds_rsp.done) x_q <= ds_rsp.res;
			jeig_pkg::ST_SQ2W: if (ds_rsp.done) c_q <= ds_rsp.res[31:0];
			jeig_pkg::ST_SQ3W: begin
				if (ds_rsp.done) begin
					s_q     <= neg_q ? -ds_rsp.res[31:0] : ds_rsp.res[31:0];
					phase_q <= '0;
					i_q     <= '0;
					j_q     <= '0;
					k_q     <= '0;
				end
			end
			jeig_pkg::ST_MAC_ACC: begin
				acc_q <= mac_sum;
				if (k_q == 2'd2) begin
					case (phase_q)
						2'd0:    b_q[i_q][j_q] <= sat_mid(rnd);
						2'd1:    a_q[i_q][j_q] <= sat_store(rnd);
						default: b_q[i_q][j_q] <= 34'(sat_store(rnd));
					endcase
					k_q <= '0;
					if (j_q == 2'd2) begin
						j_q <= '0;
						if (i_q == 2'd2) begin
							i_q     <= '0;
							phase_q <= phase_q + 2'd1;
						end else begin
							i_q <= i_q + 2'd1;
						end
					end else begin
						j_q <= j_q + 2'd1;
					end
				end else begin
					k_q <= k_q + 2'd1;
				end
			end
			jeig_pkg::ST_COPY: begin
				for (int r = 0; r < 3; r++) begin
					for (int c = 0; c < 3; c++) begin
						v_q[r][c] <= b_q[r][c][SB-1:0];
					end
				end
				off_idx_q <= '0;
				off_q     <= '0;
			end
			jeig_pkg::ST_OFF_ACC: begin
				off_q     <= off_q + 50'(mul_p[63:16]);
				off_idx_q <= off_idx_q + 3'd1;
			end
			jeig_pkg::ST_EMIT: begin
				axis_q     <= emit_idx_q;
				eig_q      <= 32'(a_q[emit_idx_q][emit_idx_q]);
				vx_q       <= 32'(v_q[0][emit_idx_q]);
				vy_q       <= 32'(v_q[1][emit_idx_q]);
				vz_q       <= 32'(v_q[2][emit_idx_q]);
				final_q    <= (emit_idx_q == 2'd2);
				emit_idx_q <= emit_idx_q + 2'd1;
			end
			default: begin
			end
		endcase
	end

	assign busy       = (state_q != jeig_pkg::ST_IDLE);
	assign done       = done_q;
	assign axis_index = axis_q;
	assign eigenvalue = eig_q;
	assign vector_x   = vx_q;
	assign vector_y   = vy_q;
	assign vector_z   = vz_q;
	assign final_axis = final_q;

endmodule

`default_nettype wire
